@@ src/swdi_pkg.sv @@
// ----------------------------------------------------------------------------
// swdi_pkg: shared types and codes for the sorted word set
// Entry, request, control and flag types used by the cell row and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package swdi_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int MAX_CHARS_DEF = 8;

    // request codes
    localparam logic [1:0] REQ_ADD       = 2'd0;
    localparam logic [1:0] REQ_SET_TILE  = 2'd1;
    localparam logic [1:0] REQ_QUERY_INS = 2'd2;
    localparam logic [1:0] REQ_QUERY_POS = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [4:0] TILE_NONE = 5'h1F;

    typedef struct packed {
        logic [63:0] key;
        logic [5:0]  ins;
        logic [4:0]  row;
        logic [4:0]  col;
    } entry_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
        logic [5:0]  idx;
        logic [3:0]  row;
        logic [3:0]  col;
    } req_t;

    typedef struct packed {
        logic commit;
        logic add;
        logic set_tile;
    } ctrl_t;

    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
        logic hit;
    } flags_t;

endpackage

`default_nettype wire

@@ src/swdi_cell.sv @@
// ----------------------------------------------------------------------------
// swdi_cell: one slot of the sorted table
// Holds one entry, registers its compare flags, shifts right on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module swdi_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 7
) (
    input  wire logic             aclk,
    input  wire swdi_pkg::req_t   req,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             match_en,
    input  wire swdi_pkg::ctrl_t  ctrl,
    input  wire logic             sel,
    input  wire swdi_pkg::entry_t left_entry,
    input  wire swdi_pkg::flags_t left_flags,
    output swdi_pkg::entry_t      entry,
    output swdi_pkg::flags_t      flags
);
    import swdi_pkg::*;

    entry_t entry_reg, entry_next;
    flags_t flags_reg, flags_next;

    always_comb begin
        flags_next.valid = 32'(CELL_IDX) < 32'(count);
        flags_next.lt    = flags_next.valid && (entry_reg.key < req.key);
        flags_next.eq    = flags_next.valid && (entry_reg.key == req.key);
        if (req.req_type == REQ_QUERY_POS) begin
            flags_next.hit = 32'(CELL_IDX) == 32'(req.idx);
        end else begin
            flags_next.hit = flags_next.valid && (entry_reg.ins == req.idx);
        end
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.commit && ctrl.add) begin
            if (sel) begin
                entry_next.key = req.key;
                entry_next.ins = 6'(count);
                entry_next.row = TILE_NONE;
                entry_next.col = TILE_NONE;
            end else if (left_flags.valid && !left_flags.lt) begin
                // left neighbour sorts after the new key: move it up one slot
                entry_next = left_entry;
            end
        end
        if (ctrl.commit && ctrl.set_tile && sel) begin
            entry_next.row = {1'b0, req.row};
            entry_next.col = {1'b0, req.col};
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (match_en) begin
            flags_reg <= flags_next;
        end
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

@@ src/sorted_word_set_dual_index_top.sv @@
// ----------------------------------------------------------------------------
// sorted_word_set_dual_index_top: sorted word table with two indexes
// Each item passes the states idle (accept), match, pick and commit; the result
// is registered at commit. A new item is taken only after the last one commits,
// as the select-and-commit sequence over the cell row is shared; pick stalls on m_ready.
// Reset: clears the word count and handshake state; cell contents stay
// undefined and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_word_set_dual_index_top #(
    parameter int CAPACITY  = swdi_pkg::CAPACITY_DEF,
    parameter int MAX_CHARS = swdi_pkg::MAX_CHARS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [63:0] s_word_key,
    input  wire logic [5:0]  s_entry_index,
    input  wire logic [3:0]  s_tile_row,
    input  wire logic [3:0]  s_tile_col,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [63:0]      m_word_out,
    output logic signed [4:0] m_tile_row_out,
    output logic signed [4:0] m_tile_col_out,
    output logic [5:0]       m_alpha_position,
    output logic [6:0]       m_entry_count
);
    import swdi_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    // only the top MAX_CHARS bytes of a word take part
    localparam logic [63:0] KEY_MASK = ~64'd0 << (64 - 8 * MAX_CHARS);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_PICK   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAPACITY-1:0] sel_reg, sel_next;
    logic [1:0]         status_reg, status_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [63:0]        m_word_reg, m_word_next;
    logic [4:0]         m_row_reg, m_row_next;
    logic [4:0]         m_col_reg, m_col_next;
    logic [5:0]         m_pos_reg, m_pos_next;
    logic [6:0]         m_count_reg, m_count_next;

    ctrl_t              ctrl;
    entry_t             cell_entry [CAPACITY];
    flags_t             cell_flags [CAPACITY];
    logic [CAPACITY-1:0] lt_vec, eq_vec, hit_vec, ins_at, hit_low;
    entry_t             sel_entry;
    logic [5:0]         sel_pos;
    logic               idx_oor;

    // ---------------------------------------------------------------------
    // Cell row: each cell compares its own entry against the request in the
    // match cycle and takes its left neighbour's entry on an insert when that entry sorts after the new key.
    // ---------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            entry_t left_e;
            flags_t left_f;
            if (gi == 0) begin : g_first
                assign left_e = '0;
                assign left_f = '0;
            end else begin : g_rest
                assign left_e = cell_entry[gi-1];
                assign left_f = cell_flags[gi-1];
            end

            swdi_cell #(
                .CELL_IDX (gi),
                .CNT_W    (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .req        (req_reg),
                .count      (count_reg),
                .match_en   (state_reg == S_MATCH),
                .ctrl       (ctrl),
                .sel        (sel_reg[gi]),
                .left_entry (left_e),
                .left_flags (left_f),
                .entry      (cell_entry[gi]),
                .flags      (cell_flags[gi])
            );

            assign lt_vec[gi]  = cell_flags[gi].lt;
            assign eq_vec[gi]  = cell_flags[gi].eq;
            assign hit_vec[gi] = cell_flags[gi].hit;
        end
    endgenerate

    // Insert slot: first cell whose key is not below the new one. The lt
    // flags form a run of ones from slot 0, so at most one bit is set.
    always_comb begin
        ins_at[0] = !lt_vec[0];
        for (int i = 1; i < CAPACITY; i++) begin
            ins_at[i] = lt_vec[i-1] && !lt_vec[i];
        end
    end

    // lowest set bit, for insertion numbers that repeat in wide tables
    assign hit_low = hit_vec & (~hit_vec + {{(CAPACITY-1){1'b0}}, 1'b1});
    assign idx_oor = 32'(req_reg.idx) >= 32'(count_reg);

    // pick cycle: status and one-hot selection of the entry concerned (none on FULL or RANGE)
    always_comb begin
        status_next = ST_OK;
        sel_next    = '0;
        case (req_reg.req_type) inside
            REQ_ADD: begin
                if (|eq_vec) begin
                    status_next = ST_DUP;
                    sel_next    = eq_vec;
                end else if (count_reg >= CNT_W'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    sel_next    = ins_at;
                end
            end
            REQ_QUERY_POS: begin
                if (idx_oor) begin
                    status_next = ST_RANGE;
                end else begin
                    sel_next    = hit_vec;
                end
            end
            REQ_SET_TILE, REQ_QUERY_INS: begin
                if (idx_oor || !(|hit_vec)) begin
                    status_next = ST_RANGE;
                end else begin
                    sel_next    = hit_low;
                end
            end
            default: begin
                status_next = ST_RANGE;
            end
        endcase
    end

    // commit cycle: read the selected entry and its position
    always_comb begin
        sel_entry = '0;
        sel_pos   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (sel_reg[i]) begin
                sel_entry = sel_entry | cell_entry[i];
                sel_pos   = sel_pos | 6'(i);
            end
        end
    end

    always_comb begin
        ctrl.commit   = (state_reg == S_COMMIT);
        ctrl.add      = (req_reg.req_type == REQ_ADD) && (status_reg == ST_OK);
        ctrl.set_tile = (req_reg.req_type == REQ_SET_TILE) && (status_reg == ST_OK);
    end

    // ---------------------------------------------------------------------
    // Sequencer. A new item is taken only in idle; the output register lets
    // the next item start while a result still waits on m_ready.
    // ---------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_word_next   = m_word_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        m_pos_next    = m_pos_reg;
        m_count_next  = m_count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next.req_type = s_req_type;
                    req_next.key      = s_word_key & KEY_MASK;
                    req_next.idx      = s_entry_index;
                    req_next.row      = s_tile_row;
                    req_next.col      = s_tile_col;
                    state_next        = S_MATCH;
                end
            end
            S_MATCH: begin
                state_next = S_PICK;
            end
            S_PICK: begin
                // hold here until the output register is free
                if (!m_valid_reg || m_ready) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                state_next = S_IDLE;
                if (ctrl.add) begin
                    count_next = count_reg + 1'b1;
                end
                m_valid_next  = 1'b1;
                m_status_next = status_reg;
                if (status_reg == ST_RANGE || status_reg == ST_FULL) begin
                    m_word_next = '0;
                    m_row_next  = TILE_NONE;
                    m_col_next  = TILE_NONE;
                    m_pos_next  = '0;
                end else if (ctrl.add) begin
                    m_word_next = req_reg.key;
                    m_row_next  = TILE_NONE;
                    m_col_next  = TILE_NONE;
                    m_pos_next  = sel_pos;
                end else if (ctrl.set_tile) begin
                    m_word_next = sel_entry.key;
                    m_row_next  = {1'b0, req_reg.row};
                    m_col_next  = {1'b0, req_reg.col};
                    m_pos_next  = sel_pos;
                end else begin
                    m_word_next = sel_entry.key;
                    m_row_next  = sel_entry.row;
                    m_col_next  = sel_entry.col;
                    m_pos_next  = sel_pos;
                end
                m_count_next = 7'(count_next);
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        if (state_reg == S_PICK) begin
            sel_reg    <= sel_next;
            status_reg <= status_next;
        end
        m_status_reg <= m_status_next;
        m_word_reg   <= m_word_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_pos_reg    <= m_pos_next;
        m_count_reg  <= m_count_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_word_out       = m_word_reg;
    assign m_tile_row_out   = m_row_reg;
    assign m_tile_col_out   = m_col_reg;
    assign m_alpha_position = m_pos_reg;
    assign m_entry_count    = m_count_reg;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("word count beyond capacity");

    a_count_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_COMMIT) |=> $stable(count_reg))
        else $error("word count moved outside commit");

    a_sel_onehot0: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMMIT) |-> $onehot0(sel_reg))
        else $error("more than one cell selected");

    a_ok_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMMIT && (status_reg == ST_OK || status_reg == ST_DUP))
        |-> $onehot(sel_reg))
        else $error("successful request without a selected cell");

endmodule

`default_nettype wire
